FILE: rtl/psp_pkg.sv
// Package: widths, types and constants shared by the Pauli string product block.
package psp_pkg;

	// Mask field width on the ports and qubits actually used.
	localparam int MASK_W      = 32;
	localparam int QUBITS      = 32;
	// Coefficient format: two's complement with FRAC_BITS fraction bits.
	localparam int COEFF_WIDTH = 24;
	localparam int FRAC_BITS   = 16;

	// Exact product, exact sum of two products, and sum widened for the shift.
	localparam int PROD_W = 2 * COEFF_WIDTH;
	localparam int SUM_W  = PROD_W + 1;
	localparam int WIDE_W = SUM_W + FRAC_BITS;
	localparam int CNT_W  = $clog2(MASK_W + 1);

	// Qubits at or above QUBITS are forced to identity.
	localparam logic [MASK_W-1:0] QUBIT_MASK = (QUBITS >= MASK_W) ? {MASK_W{1'b1}} :
		MASK_W'((65'd1 << QUBITS) - 65'd1);

	typedef logic [MASK_W-1:0]              mask_t;
	typedef logic signed [COEFF_WIDTH-1:0]  coeff_t;
	typedef logic signed [PROD_W-1:0]       prod_t;
	typedef logic signed [SUM_W-1:0]        sum_t;

	// Phase codes.
	typedef enum logic [1:0] {
		PH_ONE     = 2'd0,
		PH_NEG_I   = 2'd1,
		PH_NEG_ONE = 2'd2,
		PH_POS_I   = 2'd3
	} phase_t;

endpackage

FILE: rtl/psp_if.sv
// Interfaces: operand pair request channel and product result channel.
interface psp_in_if;
	logic            valid;
	logic            ready;
	psp_pkg::mask_t  a_x_bits;
	psp_pkg::mask_t  a_z_bits;
	psp_pkg::mask_t  b_x_bits;
	psp_pkg::mask_t  b_z_bits;
	psp_pkg::coeff_t a_re;
	psp_pkg::coeff_t a_im;
	psp_pkg::coeff_t b_re;
	psp_pkg::coeff_t b_im;

	modport source (
		output valid, a_x_bits, a_z_bits, b_x_bits, b_z_bits, a_re, a_im, b_re, b_im,
		input  ready
	);
	modport sink (
		input  valid, a_x_bits, a_z_bits, b_x_bits, b_z_bits, a_re, a_im, b_re, b_im,
		output ready
	);
endinterface

interface psp_out_if;
	logic            valid;
	logic            ready;
	psp_pkg::mask_t  prod_x_bits;
	psp_pkg::mask_t  prod_z_bits;
	logic [1:0]      phase_index;
	psp_pkg::coeff_t prod_re;
	psp_pkg::coeff_t prod_im;
	logic            saturated;

	modport source (
		output valid, prod_x_bits, prod_z_bits, phase_index, prod_re, prod_im, saturated,
		input  ready
	);
	modport sink (
		input  valid, prod_x_bits, prod_z_bits, phase_index, prod_re, prod_im, saturated,
		output ready
	);
endinterface

FILE: rtl/pauli_string_product.sv
// Top level: three-stage pipeline forming the product of two Pauli strings.
//
//   channel | dir | contents
//   --------+-----+-------------------------------------------------------
//   pair    | in  | x/z masks of both strings, both complex coefficients
//   prod    | out | product masks, phase code, phased coefficient, sat flag
//
// One request per cycle while the result channel is not stalled; each request passes the stage 1, 2 and 3 registers.
// Stage 1 holds the four coefficient multipliers, stage 2 the popcounts and
// product sums, stage 3 the phase rotation, truncation and clamp.
// Reset clears the stage valid bits only. A stage advances when the stage
// after it is empty or moving, so a stalled result holds and nothing is lost.
module pauli_string_product (
	input  logic      clk,
	input  logic      arst_n,
	psp_in_if.sink    pair,
	psp_out_if.source prod
);
	import psp_pkg::*;

	function automatic logic [CNT_W-1:0] pop_count(input mask_t v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < MASK_W; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

	// Stage valid bits and advance conditions.
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3       = !v_s3 || prod.ready;
	assign adv2       = !v_s2 || adv3;
	assign adv1       = !v_s1 || adv2;
	assign pair.ready = adv1;

	// Stage 1 payload.
	mask_t rx_s1, rz_s1, ab_s1, ya_s1, yb_s1;
	prod_t rr_s1, ii_s1, ri_s1, ir_s1;

	// Stage 2 payload.
	mask_t  rx_s2, rz_s2;
	phase_t ph_s2;
	sum_t   re_s2, im_s2;

	// Stage 3 payload.
	mask_t      rx_s3, rz_s3;
	logic [1:0] ph_s3;
	coeff_t     re_s3, im_s3;
	logic       sat_s3;

	// Stage 1 inputs after masking off unused qubits.
	mask_t ax, az, bx, bz;
	assign ax = pair.a_x_bits & QUBIT_MASK;
	assign az = pair.a_z_bits & QUBIT_MASK;
	assign bx = pair.b_x_bits & QUBIT_MASK;
	assign bz = pair.b_z_bits & QUBIT_MASK;

	// Stage 2 phase terms.
	logic [CNT_W-1:0] pc_ab, pc_ya, pc_yb, pc_yr;
	logic [1:0]       ph_sum;
	assign pc_ab  = pop_count(ab_s1);
	assign pc_ya  = pop_count(ya_s1);
	assign pc_yb  = pop_count(yb_s1);
	assign pc_yr  = pop_count(rx_s1 & rz_s1);
	assign ph_sum = {pc_ab[0], 1'b0} + pc_ya[1:0] + pc_yb[1:0] - pc_yr[1:0];

	// Stage 3 rotation, floor shift and clamp.
	sum_t                  re_pick, im_pick;
	logic signed [WIDE_W-1:0] re_wide, im_wide;
	sum_t                  re_shr, im_shr;
	logic                  re_fits, im_fits;
	coeff_t                re_sat, im_sat;

	always_comb begin
		unique case (ph_s2)
			PH_ONE: begin
				re_pick = re_s2;
				im_pick = im_s2;
			end
			PH_NEG_I: begin
				re_pick = im_s2;
				im_pick = -re_s2;
			end
			PH_NEG_ONE: begin
				re_pick = -re_s2;
				im_pick = -im_s2;
			end
			PH_POS_I: begin
				re_pick = -im_s2;
				im_pick = re_s2;
			end
			default: begin
				re_pick = re_s2;
				im_pick = im_s2;
			end
		endcase
		re_wide = WIDE_W'(re_pick);
		im_wide = WIDE_W'(im_pick);
		re_shr  = sum_t'(re_wide >>> FRAC_BITS);
		im_shr  = sum_t'(im_wide >>> FRAC_BITS);
		re_fits = (re_shr[SUM_W-1:COEFF_WIDTH-1] == {(SUM_W-COEFF_WIDTH+1){1'b0}}) ||
		          (re_shr[SUM_W-1:COEFF_WIDTH-1] == {(SUM_W-COEFF_WIDTH+1){1'b1}});
		im_fits = (im_shr[SUM_W-1:COEFF_WIDTH-1] == {(SUM_W-COEFF_WIDTH+1){1'b0}}) ||
		          (im_shr[SUM_W-1:COEFF_WIDTH-1] == {(SUM_W-COEFF_WIDTH+1){1'b1}});
		re_sat  = re_fits ? re_shr[COEFF_WIDTH-1:0]
		                  : {re_shr[SUM_W-1], {(COEFF_WIDTH-1){~re_shr[SUM_W-1]}}};
		im_sat  = im_fits ? im_shr[COEFF_WIDTH-1:0]
		                  : {im_shr[SUM_W-1], {(COEFF_WIDTH-1){~im_shr[SUM_W-1]}}};
	end

	// Advance valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pair.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Stage 1: masks and the four coefficient products.
	always_ff @(posedge clk) begin
		if (adv1 && pair.valid) begin
			rx_s1 <= ax ^ bx;
			rz_s1 <= az ^ bz;
			ab_s1 <= ax & bz;
			ya_s1 <= ax & az;
			yb_s1 <= bx & bz;
			rr_s1 <= pair.a_re * pair.b_re;
			ii_s1 <= pair.a_im * pair.b_im;
			ri_s1 <= pair.a_re * pair.b_im;
			ir_s1 <= pair.a_im * pair.b_re;
		end
	end

	// Stage 2: phase code and exact product parts.
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			rx_s2 <= rx_s1;
			rz_s2 <= rz_s1;
			ph_s2 <= phase_t'(ph_sum);
			re_s2 <= sum_t'(rr_s1) - sum_t'(ii_s1);
			im_s2 <= sum_t'(ri_s1) + sum_t'(ir_s1);
		end
	end

	// Stage 3: hold the finished result for the output channel.
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			rx_s3  <= rx_s2;
			rz_s3  <= rz_s2;
			ph_s3  <= ph_s2;
			re_s3  <= re_sat;
			im_s3  <= im_sat;
			sat_s3 <= !re_fits || !im_fits;
		end
	end

	assign prod.valid       = v_s3;
	assign prod.prod_x_bits = rx_s3;
	assign prod.prod_z_bits = rz_s3;
	assign prod.phase_index = ph_s3;
	assign prod.prod_re     = re_s3;
	assign prod.prod_im     = im_s3;
	assign prod.saturated   = sat_s3;

endmodule

FILE: tb/tb_top.sv
// Testbench for pauli_string_product: directed table plus random pairs, checked by a predictor.
module tb_top;
	import psp_pkg::*;

	typedef struct packed {
		mask_t  ax;
		mask_t  az;
		mask_t  bx;
		mask_t  bz;
		coeff_t ar;
		coeff_t ai;
		coeff_t br;
		coeff_t bi;
	} term_pair_t;

	typedef struct packed {
		mask_t  x;
		mask_t  z;
		phase_t ph;
		coeff_t re;
		coeff_t im;
		logic   sat;
	} term_prod_t;

	typedef struct packed {
		term_pair_t op;
		logic       known;
		term_prod_t want;
	} stim_row_t;

	localparam coeff_t C_ONE = coeff_t'(1 << FRAC_BITS);
	localparam coeff_t C_MAX = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
	localparam coeff_t C_MIN = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
	localparam int RANDOM_PAIRS = 900;
	localparam int STEADY_FROM  = 780;

	logic clk;
	logic arst_n;

	psp_in_if  pair_ch ();
	psp_out_if prod_ch ();

	pauli_string_product DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch.sink),
		.prod   (prod_ch.source)
	);

	// Typed expectation travelling alongside the request being driven
	logic        pend_known;
	term_prod_t  pend_want;

	term_prod_t  awaited_products[$];
	stim_row_t   stim_rows[$];
	int          mismatches;
	int          requests_sent;
	int          results_seen;
	int          phase_seen[4];
	int          sat_seen;
	bit          steady;

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predict the product masks, phase and rotated, floored, clamped coefficient
	function automatic coeff_t clamp_part(longint v, inout logic flag);
		longint hi;
		longint lo;
		hi = longint'(C_MAX);
		lo = -hi - 1;
		if (v > hi) begin
			flag = 1'b1;
			return C_MAX;
		end
		if (v < lo) begin
			flag = 1'b1;
			return C_MIN;
		end
		return coeff_t'(v);
	endfunction

	function automatic term_prod_t pauli_product(term_pair_t p);
		term_prod_t res;
		mask_t      ax, az, bx, bz;
		int         k;
		longint     ar, ai, br, bi, r, i, pr, pi;
		logic       flag;
		ax = p.ax & QUBIT_MASK;
		az = p.az & QUBIT_MASK;
		bx = p.bx & QUBIT_MASK;
		bz = p.bz & QUBIT_MASK;
		res.x = ax ^ bx;
		res.z = az ^ bz;
		k = 2 * $countones(ax & bz) + $countones(ax & az) + $countones(bx & bz)
			- $countones(res.x & res.z);
		res.ph = phase_t'(k[1:0]);
		ar = longint'($signed(p.ar));
		ai = longint'($signed(p.ai));
		br = longint'($signed(p.br));
		bi = longint'($signed(p.bi));
		r = ar * br - ai * bi;
		i = ar * bi + ai * br;
		// rotate first, then floor to the coefficient format
		case (res.ph)
			PH_ONE: begin
				pr = r;
				pi = i;
			end
			PH_NEG_I: begin
				pr = i;
				pi = -r;
			end
			PH_NEG_ONE: begin
				pr = -r;
				pi = -i;
			end
			default: begin
				pr = -i;
				pi = r;
			end
		endcase
		pr = pr >>> FRAC_BITS;
		pi = pi >>> FRAC_BITS;
		flag = 1'b0;
		res.re = clamp_part(pr, flag);
		res.im = clamp_part(pi, flag);
		res.sat = flag;
		return res;
	endfunction

	function automatic term_pair_t ops(mask_t ax, mask_t az, mask_t bx, mask_t bz,
			coeff_t ar, coeff_t ai, coeff_t br, coeff_t bi);
		term_pair_t p;
		p = '{ax: ax, az: az, bx: bx, bz: bz, ar: ar, ai: ai, br: br, bi: bi};
		return p;
	endfunction

	function automatic term_prod_t res(mask_t x, mask_t z, phase_t ph, coeff_t re,
			coeff_t im, logic sat);
		term_prod_t r;
		r = '{x: x, z: z, ph: ph, re: re, im: im, sat: sat};
		return r;
	endfunction

	function automatic void add_row(term_pair_t op, logic known, term_prod_t want);
		stim_row_t row;
		row.op = op;
		row.known = known;
		row.want = want;
		stim_rows.insert(stim_rows.size(), row);
	endfunction

	// Random masks: mostly dense, some sparse to spread the phases, some extremes
	function automatic mask_t random_mask();
		mask_t m;
		m = '0;
		case ($urandom_range(0, 7))
			0, 1, 2: begin
				repeat ($urandom_range(1, 4)) m[$urandom_range(0, MASK_W-1)] = 1'b1;
			end
			3: begin
				m = $urandom_range(0, 1) ? '1 : '0;
			end
			default: begin
				m = mask_t'($urandom);
			end
		endcase
		return m;
	endfunction

	// Random coefficients: extremes, small magnitudes that stay in range, full range
	function automatic coeff_t random_coeff();
		coeff_t c;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 5))
					0: c = C_MAX;
					1: c = C_MIN;
					2: c = C_ONE;
					3: c = -C_ONE;
					4: c = coeff_t'(1);
					default: c = coeff_t'(-1);
				endcase
			end
			1, 2, 3: begin
				c = coeff_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
			end
			default: begin
				c = coeff_t'($urandom);
			end
		endcase
		return c;
	endfunction

	function automatic term_pair_t random_pair();
		return ops(random_mask(), random_mask(), random_mask(), random_mask(),
			random_coeff(), random_coeff(), random_coeff(), random_coeff());
	endfunction

	// Offer one request, with an occasional idle burst ahead of it
	task automatic send(term_pair_t op, logic known, term_prod_t want);
		if (!steady && $urandom_range(0, 3) == 0) begin
			pair_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		pair_ch.a_x_bits <= op.ax;
		pair_ch.a_z_bits <= op.az;
		pair_ch.b_x_bits <= op.bx;
		pair_ch.b_z_bits <= op.bz;
		pair_ch.a_re     <= op.ar;
		pair_ch.a_im     <= op.ai;
		pair_ch.b_re     <= op.br;
		pair_ch.b_im     <= op.bi;
		pend_known       <= known;
		pend_want        <= want;
		pair_ch.valid    <= 1'b1;
		do @(posedge clk); while (!pair_ch.ready);
	endtask

	task automatic compare(term_prod_t want, term_prod_t got);
		if (got.x !== want.x) begin
			$error("prod_x_bits: expected %h, got %h", want.x, got.x);
			mismatches++;
		end
		if (got.z !== want.z) begin
			$error("prod_z_bits: expected %h, got %h", want.z, got.z);
			mismatches++;
		end
		if (got.ph !== want.ph) begin
			$error("phase_index: expected %0d, got %0d", want.ph, got.ph);
			mismatches++;
		end
		if (got.re !== want.re) begin
			$error("prod_re: expected %0d, got %0d", $signed(want.re), $signed(got.re));
			mismatches++;
		end
		if (got.im !== want.im) begin
			$error("prod_im: expected %0d, got %0d", $signed(want.im), $signed(got.im));
			mismatches++;
		end
		if (got.sat !== want.sat) begin
			$error("saturated: expected %0b, got %0b", want.sat, got.sat);
			mismatches++;
		end
	endtask

	// Record each accepted request, then check each accepted result
	always @(posedge clk) begin
		term_pair_t op;
		term_prod_t got;
		if (arst_n) begin
			if (pair_ch.valid && pair_ch.ready) begin
				op = ops(pair_ch.a_x_bits, pair_ch.a_z_bits, pair_ch.b_x_bits,
					pair_ch.b_z_bits, pair_ch.a_re, pair_ch.a_im, pair_ch.b_re,
					pair_ch.b_im);
				awaited_products.insert(awaited_products.size(),
					pend_known ? pend_want : pauli_product(op));
				requests_sent++;
			end
			if (prod_ch.valid && prod_ch.ready) begin
				got = res(prod_ch.prod_x_bits, prod_ch.prod_z_bits,
					phase_t'(prod_ch.phase_index), prod_ch.prod_re, prod_ch.prod_im,
					prod_ch.saturated);
				results_seen++;
				phase_seen[prod_ch.phase_index]++;
				if (prod_ch.saturated === 1'b1)
					sat_seen++;
				if (awaited_products.size() == 0) begin
					$error("result with no request outstanding: x %h z %h",
						got.x, got.z);
					mismatches++;
				end else begin
					compare(awaited_products.pop_front(), got);
				end
			end
		end
	end

	// Result side: ready in runs, stalled in bursts until the closing stretch
	initial begin
		prod_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			prod_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!steady && $urandom_range(0, 2) == 0) begin
				prod_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Request side: reset, directed table, random pairs, drain
	initial begin
		mismatches    = 0;
		requests_sent = 0;
		results_seen  = 0;
		sat_seen      = 0;
		phase_seen    = '{0, 0, 0, 0};
		steady        = 1'b0;
		arst_n           <= 1'b0;
		pair_ch.valid    <= 1'b0;
		pair_ch.a_x_bits <= '0;
		pair_ch.a_z_bits <= '0;
		pair_ch.b_x_bits <= '0;
		pair_ch.b_z_bits <= '0;
		pair_ch.a_re     <= '0;
		pair_ch.a_im     <= '0;
		pair_ch.b_re     <= '0;
		pair_ch.b_im     <= '0;
		pend_known       <= 1'b0;
		pend_want        <= '0;

		// zero, unit and extreme coefficients on identity strings
		add_row(ops('0, '0, '0, '0, '0, '0, '0, '0), 1'b1,
			res('0, '0, PH_ONE, '0, '0, 1'b0));
		add_row(ops('0, '0, '0, '0, C_ONE, '0, C_ONE, '0), 1'b1,
			res('0, '0, PH_ONE, C_ONE, '0, 1'b0));
		add_row(ops('0, '0, '0, '0, C_MIN, '0, C_MIN, '0), 1'b1,
			res('0, '0, PH_ONE, C_MAX, '0, 1'b1));
		add_row(ops('0, '0, '0, '0, C_MIN, '0, C_MAX, '0), 1'b1,
			res('0, '0, PH_ONE, C_MIN, '0, 1'b1));
		add_row(ops('0, '0, '0, '0, '0, C_MIN, '0, C_MIN), 1'b1,
			res('0, '0, PH_ONE, C_MIN, '0, 1'b1));
		add_row(ops('0, '0, '0, '0, C_MIN, '0, '0, C_MIN), 1'b1,
			res('0, '0, PH_ONE, '0, C_MAX, 1'b1));
		add_row(ops('0, '0, '0, '0, C_MAX, '0, C_ONE, '0), 1'b1,
			res('0, '0, PH_ONE, C_MAX, '0, 1'b0));
		add_row(ops('0, '0, '0, '0, C_MIN, '0, C_ONE, '0), 1'b1,
			res('0, '0, PH_ONE, C_MIN, '0, 1'b0));
		// floor toward minus infinity on the smallest step
		add_row(ops('0, '0, '0, '0, coeff_t'(1), '0, coeff_t'(-1), '0), 1'b1,
			res('0, '0, PH_ONE, coeff_t'(-1), '0, 1'b0));
		add_row(ops('0, '0, '0, '0, coeff_t'(1), '0, coeff_t'(1), '0), 1'b1,
			res('0, '0, PH_ONE, '0, '0, 1'b0));
		// single- and two-qubit products covering every phase
		add_row(ops(1, '0, '0, 1, C_ONE, '0, C_ONE, '0), 1'b1,
			res(1, 1, PH_NEG_I, '0, -C_ONE, 1'b0));
		add_row(ops('0, 1, 1, '0, C_ONE, '0, C_ONE, '0), 1'b1,
			res(1, 1, PH_POS_I, '0, C_ONE, 1'b0));
		add_row(ops(1, 1, 1, 1, C_ONE, '0, C_ONE, '0), 1'b1,
			res('0, '0, PH_ONE, C_ONE, '0, 1'b0));
		add_row(ops(1, '0, 1, 1, C_ONE, '0, C_ONE, '0), 1'b1,
			res('0, 1, PH_POS_I, '0, C_ONE, 1'b0));
		add_row(ops(3, '0, '0, 3, C_ONE, '0, C_ONE, '0), 1'b1,
			res(3, 3, PH_NEG_ONE, -C_ONE, '0, 1'b0));
		// rotation happens before the floor
		add_row(ops(1, '0, '0, 1, coeff_t'(1), '0, coeff_t'(1), '0), 1'b1,
			res(1, 1, PH_NEG_I, '0, coeff_t'(-1), 1'b0));
		add_row(ops(3, '0, '0, 3, coeff_t'(1), '0, coeff_t'(1), '0), 1'b0, '0);
		// full and patterned strings, top qubit alone, strings of unequal length
		add_row(ops('1, '1, '1, '1, C_MAX, C_MAX, C_MAX, C_MAX), 1'b0, '0);
		add_row(ops('1, '0, '0, '1, C_MIN, C_MAX, C_MAX, C_MIN), 1'b0, '0);
		add_row(ops(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
			coeff_t'(24'h123456), coeff_t'(24'hFEDCBA), coeff_t'(24'h00F00F),
			coeff_t'(24'h800001)), 1'b0, '0);
		add_row(ops(32'h8000_0000, '0, '0, 32'h8000_0000, coeff_t'(24'h4000),
			coeff_t'(24'hFFC000), coeff_t'(24'h8000), coeff_t'(24'h7FFF)), 1'b0, '0);
		add_row(ops(32'h0000_FFFF, 32'h0000_00FF, 32'hFFFF_FFFF, 32'hF0F0_F0F0,
			coeff_t'(24'h008000), coeff_t'(24'h008000), coeff_t'(24'hFF8000),
			coeff_t'(24'h010001)), 1'b0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[n])
			send(stim_rows[n].op, stim_rows[n].known, stim_rows[n].want);
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			if (n == STEADY_FROM)
				steady = 1'b1;
			send(random_pair(), 1'b0, '0);
		end
		pair_ch.valid <= 1'b0;

		// drain, then allow the pipeline time to show any stray result
		while (awaited_products.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("tb_top: %0d requests driven, %0d products checked, %0d saturated",
			requests_sent, results_seen, sat_seen);
		$display("tb_top: phases seen 1:%0d -i:%0d -1:%0d i:%0d",
			phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3]);
		if (mismatches == 0 && awaited_products.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
